// ===== rtl/ncs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

   localparam int PAGE_BYTES_DEF      = 2048;
   localparam int PAGES_PER_BLOCK_DEF = 64;
   localparam int SPARE_BYTES_DEF     = 64;
   localparam int ID_BYTES_DEF        = 5;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_PROGRAM = 3'd1;
   localparam logic [2:0] OP_ERASE   = 3'd2;
   localparam logic [2:0] OP_READ_ID = 3'd3;
   localparam logic [2:0] OP_SPARE   = 3'd4;
   localparam logic [2:0] OP_ADVANCE = 3'd5;

   localparam logic [2:0] K_CMD    = 3'd0;
   localparam logic [2:0] K_ADDR   = 3'd1;
   localparam logic [2:0] K_WAIT   = 3'd2;
   localparam logic [2:0] K_RDATA  = 3'd3;
   localparam logic [2:0] K_WDATA  = 3'd4;
   localparam logic [2:0] K_STATUS = 3'd5;
   localparam logic [2:0] K_DONE   = 3'd6;

   localparam logic [7:0] CMD_READ      = 8'h00;
   localparam logic [7:0] CMD_READ_GO   = 8'h30;
   localparam logic [7:0] CMD_PROG      = 8'h80;
   localparam logic [7:0] CMD_PROG_GO   = 8'h10;
   localparam logic [7:0] CMD_ERASE     = 8'h60;
   localparam logic [7:0] CMD_ERASE_GO  = 8'hD0;
   localparam logic [7:0] CMD_STATUS    = 8'h70;
   localparam logic [7:0] CMD_READ_ID   = 8'h90;

   localparam logic [2:0] SEQ_READ  = 3'd0;
   localparam logic [2:0] SEQ_PROG  = 3'd1;
   localparam logic [2:0] SEQ_ERASE = 3'd2;
   localparam logic [2:0] SEQ_ID    = 3'd3;
   localparam logic [2:0] SEQ_DONE  = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [26:0] flash_address;
      logic [24:0] byte_count;
      logic [9:0]  block_number;
   } req_type;

   typedef struct packed {
      logic [2:0]  cycle_kind;
      logic [11:0] cycle_value;
      logic        final_address;
      logic        last;
      logic        read_pending;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  seq;
      logic [15:0] col;
      logic [15:0] row;
      logic [11:0] count;
      logic        pending;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/ncs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncs_front #(
   parameter int PAGE_BYTES      = 2048,
   parameter int PAGES_PER_BLOCK = 64,
   parameter int SPARE_BYTES     = 64,
   parameter int ID_BYTES        = 5
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  ncs_pkg::req_type req_item,
   input  wire              q_full,
   output logic             q_push,
   output ncs_pkg::job_type q_job
);
   import ncs_pkg::*;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   logic [26:0] next_addr_ff, next_addr_in;
   logic [24:0] remain_ff, remain_in;
   logic        active_ff, active_in;

   logic [PAGE_SHIFT-1:0] col, adv_col;
   logic [26:0] row_full, adv_row_full;
   logic        fits;
   logic [24:0] first, seg;
   logic [19:0] spare_row;
   logic        accept;

   assign accept       = push && !q_full;
   assign q_push       = accept;
   assign col          = req_item.flash_address[PAGE_SHIFT-1:0];
   assign row_full     = req_item.flash_address >> PAGE_SHIFT;
   assign adv_col      = next_addr_ff[PAGE_SHIFT-1:0];
   assign adv_row_full = next_addr_ff >> PAGE_SHIFT;
   assign fits         = ({1'b0, 25'(col)} + {1'b0, req_item.byte_count})
                         <= 26'(PAGE_BYTES);
   assign first        = 25'(PAGE_BYTES) - 25'(col);
   assign seg          = (remain_ff > 25'(PAGE_BYTES)) ? 25'(PAGE_BYTES) : remain_ff;
   assign spare_row    = 20'(req_item.block_number) * 20'(PAGES_PER_BLOCK);

   always_comb begin
      next_addr_in = next_addr_ff;
      remain_in    = remain_ff;
      active_in    = active_ff;
      q_job.seq    = SEQ_DONE;
      q_job.col    = 16'(col);
      q_job.row    = row_full[15:0];
      q_job.count  = 12'd0;
      case (req_item.operation)
         OP_READ: begin
            q_job.seq = SEQ_READ;
            if (fits) begin
               q_job.count  = req_item.byte_count[11:0];
               next_addr_in = 27'd0;
               remain_in    = 25'd0;
               active_in    = 1'b0;
            end else begin
               q_job.count  = first[11:0];
               next_addr_in = req_item.flash_address + 27'(first);
               remain_in    = req_item.byte_count - first;
               active_in    = (req_item.byte_count - first) != 25'd0;
            end
         end
         OP_PROGRAM: begin
            q_job.seq   = SEQ_PROG;
            q_job.count = (req_item.byte_count > 25'(PAGE_BYTES)) ?
                          12'(PAGE_BYTES) : req_item.byte_count[11:0];
         end
         OP_ERASE: begin
            q_job.seq = SEQ_ERASE;
         end
         OP_READ_ID: begin
            q_job.seq   = SEQ_ID;
            q_job.count = 12'(ID_BYTES);
         end
         OP_SPARE: begin
            q_job.seq   = SEQ_READ;
            q_job.col   = 16'(PAGE_BYTES);
            q_job.row   = spare_row[15:0];
            q_job.count = 12'(SPARE_BYTES);
         end
         OP_ADVANCE: begin
            if (active_ff) begin
               q_job.seq    = SEQ_READ;
               q_job.col    = 16'(adv_col);
               q_job.row    = adv_row_full[15:0];
               q_job.count  = seg[11:0];
               next_addr_in = next_addr_ff + 27'(seg);
               remain_in    = remain_ff - seg;
               active_in    = (remain_ff - seg) != 25'd0;
            end
         end
         default: begin
            q_job.seq = SEQ_DONE;
         end
      endcase
      q_job.pending = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_addr_ff <= 27'd0;
         remain_ff    <= 25'd0;
         active_ff    <= 1'b0;
      end else if (accept) begin
         next_addr_ff <= next_addr_in;
         remain_ff    <= remain_in;
         active_ff    <= active_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fit_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.operation == OP_READ && fits |=> !active_ff)
      else $error("single-page read left segments pending");
   a_active_remain: assert property (@(posedge clock) disable iff (reset)
      active_ff == (remain_ff != 25'd0))
      else $error("pending flag disagrees with remaining count");
`endif

endmodule

`default_nettype wire

// ===== rtl/ncs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncs_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              wr_en,
   input  ncs_pkg::job_type wr_job,
   output logic             full,
   input  wire              rd_en,
   output ncs_pkg::job_type rd_job,
   output logic             empty
);
   import ncs_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type       mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign full   = count_ff == CW'(QUEUE_DEPTH);
   assign empty  = count_ff == '0;
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_job = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + CW'(1);
      else if (do_rd && !do_wr) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem[wr_ptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr)
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         if (do_rd)
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
   end

`ifndef NO_ASSERTIONS
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      do_wr && !do_rd |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count missed a write");
`endif

endmodule

`default_nettype wire

// ===== rtl/ncs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncs_back (
   input  wire              clock,
   input  wire              reset,
   input  wire              q_empty,
   input  ncs_pkg::job_type q_job,
   output logic             q_pop,
   output logic             empty,
   input  wire              pop,
   output ncs_pkg::rsp_type rsp_item
);
   import ncs_pkg::*;

   logic [3:0] step_ff, step_in;
   rsp_type    out_ff, cur;
   logic       out_valid_ff, out_valid_in;
   logic       load;

   assign load     = !q_empty && (!out_valid_ff || pop);
   assign q_pop    = load && cur.last;
   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   always_comb begin
      cur.cycle_kind    = K_DONE;
      cur.cycle_value   = 12'd0;
      cur.final_address = 1'b0;
      cur.last          = 1'b0;
      cur.read_pending  = q_job.pending;
      case (q_job.seq)
         SEQ_READ, SEQ_PROG: begin
            case (step_ff)
               4'd0: begin
                  cur.cycle_kind  = K_CMD;
                  cur.cycle_value = (q_job.seq == SEQ_READ) ? 12'(CMD_READ) : 12'(CMD_PROG);
               end
               4'd1: begin
                  cur.cycle_kind  = K_ADDR;
                  cur.cycle_value = 12'(q_job.col[7:0]);
               end
               4'd2: begin
                  cur.cycle_kind  = K_ADDR;
                  cur.cycle_value = 12'(q_job.col[15:8]);
               end
               4'd3: begin
                  cur.cycle_kind  = K_ADDR;
                  cur.cycle_value = 12'(q_job.row[7:0]);
               end
               4'd4: begin
                  cur.cycle_kind    = K_ADDR;
                  cur.cycle_value   = 12'(q_job.row[15:8]);
                  cur.final_address = 1'b1;
               end
               4'd5: begin
                  if (q_job.seq == SEQ_READ) begin
                     cur.cycle_kind  = K_CMD;
                     cur.cycle_value = 12'(CMD_READ_GO);
                  end else begin
                     cur.cycle_kind  = K_WDATA;
                     cur.cycle_value = q_job.count;
                  end
               end
               4'd6: begin
                  if (q_job.seq == SEQ_READ) begin
                     cur.cycle_kind = K_WAIT;
                  end else begin
                     cur.cycle_kind  = K_CMD;
                     cur.cycle_value = 12'(CMD_PROG_GO);
                  end
               end
               4'd7: begin
                  if (q_job.seq == SEQ_READ) begin
                     cur.cycle_kind  = K_RDATA;
                     cur.cycle_value = q_job.count;
                     cur.last        = 1'b1;
                  end else begin
                     cur.cycle_kind = K_WAIT;
                  end
               end
               4'd8: begin
                  cur.cycle_kind  = K_CMD;
                  cur.cycle_value = 12'(CMD_STATUS);
               end
               default: begin
                  cur.cycle_kind = K_STATUS;
                  cur.last       = 1'b1;
               end
            endcase
         end
         SEQ_ERASE: begin
            case (step_ff)
               4'd0: begin
                  cur.cycle_kind  = K_CMD;
                  cur.cycle_value = 12'(CMD_ERASE);
               end
               4'd1: begin
                  cur.cycle_kind  = K_ADDR;
                  cur.cycle_value = 12'(q_job.row[7:0]);
               end
               4'd2: begin
                  cur.cycle_kind    = K_ADDR;
                  cur.cycle_value   = 12'(q_job.row[15:8]);
                  cur.final_address = 1'b1;
               end
               4'd3: begin
                  cur.cycle_kind  = K_CMD;
                  cur.cycle_value = 12'(CMD_ERASE_GO);
               end
               4'd4: begin
                  cur.cycle_kind = K_WAIT;
               end
               4'd5: begin
                  cur.cycle_kind  = K_CMD;
                  cur.cycle_value = 12'(CMD_STATUS);
               end
               default: begin
                  cur.cycle_kind = K_STATUS;
                  cur.last       = 1'b1;
               end
            endcase
         end
         SEQ_ID: begin
            case (step_ff)
               4'd0: begin
                  cur.cycle_kind  = K_CMD;
                  cur.cycle_value = 12'(CMD_READ_ID);
               end
               4'd1: begin
                  cur.cycle_kind    = K_ADDR;
                  cur.final_address = 1'b1;
               end
               4'd2: begin
                  cur.cycle_kind = K_WAIT;
               end
               default: begin
                  cur.cycle_kind  = K_RDATA;
                  cur.cycle_value = q_job.count;
                  cur.last        = 1'b1;
               end
            endcase
         end
         default: begin
            cur.cycle_kind = K_DONE;
            cur.last       = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !pop;
      if (load) begin
         out_valid_in = 1'b1;
         step_in      = cur.last ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_ff <= cur;
   end

`ifndef NO_ASSERTIONS
   a_step_moves: assert property (@(posedge clock) disable iff (reset)
      load && !cur.last |=> step_ff == $past(step_ff) + 4'd1)
      else $error("sequencer step did not advance");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff && !q_empty |=> out_valid_ff)
      else $error("output register idle with work queued");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 4'd9)
      else $error("sequencer step out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/nand_command_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          item        handshake
// request   push, full, req_item           req_type    taken on push && !full
// response  pop, empty, rsp_item           rsp_type    taken on pop && !empty
//
// One bus cycle item leaves per clock while the response port takes them; a request yields 1 to 10 of them,
// set by the step counter of the back sequencer.
// Requests are taken one per clock while the two-entry job queue has room.
// A request's first response is registered in the job queue, then in the back output register.
// Reset is synchronous; it clears read segment state, queue and output.
// A stalled response port backs up the queue, then raises full.

module nand_command_sequencer_top #(
   parameter int PAGE_BYTES      = ncs_pkg::PAGE_BYTES_DEF,
   parameter int PAGES_PER_BLOCK = ncs_pkg::PAGES_PER_BLOCK_DEF,
   parameter int SPARE_BYTES     = ncs_pkg::SPARE_BYTES_DEF,
   parameter int ID_BYTES        = ncs_pkg::ID_BYTES_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   output logic             full,
   input  ncs_pkg::req_type req_item,
   output logic             empty,
   input  wire              pop,
   output ncs_pkg::rsp_type rsp_item
);
   import ncs_pkg::*;

   job_type f_job, b_job;
   logic    f_push, q_full, q_empty, b_pop;

   assign full = q_full;

   ncs_front #(
      .PAGE_BYTES      (PAGE_BYTES),
      .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
      .SPARE_BYTES     (SPARE_BYTES),
      .ID_BYTES        (ID_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (f_push),
      .q_job    (f_job)
   );

   ncs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (f_push),
      .wr_job (f_job),
      .full   (q_full),
      .rd_en  (b_pop),
      .rd_job (b_job),
      .empty  (q_empty)
   );

   ncs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_job    (b_job),
      .q_pop    (b_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// ===== tb/nand_command_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

module nand_command_sequencer_top_tb;
   import ncs_pkg::*;

   localparam int PG      = PAGE_BYTES_DEF;
   localparam int PPB     = PAGES_PER_BLOCK_DEF;
   localparam int SPARE_N = SPARE_BYTES_DEF;
   localparam int ID_N    = ID_BYTES_DEF;

   // operation codes the block treats as no-ops, answered with a single done item
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT  = 2000;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_item = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_item;

   nand_command_sequencer_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // read segment state mirrored from the block
   logic [26:0] rd_next_addr = '0;
   logic [24:0] rd_left      = '0;
   logic        rd_active    = 1'b0;

   rsp_type bus_cycles_due[$];
   rsp_type item_cycles[$];

   bit idle_on = 1'b1;
   int rx_wait = 0;
   int errors  = 0;
   int cycles_checked = 0;
   int op_seen [8];

   rsp_type got;
   rsp_type want;

   function automatic void add_cycle(logic [2:0] kind, longint value, logic fin);
      rsp_type c;
      c = '0;
      c.cycle_kind    = kind;
      c.cycle_value   = 12'(value);
      c.final_address = fin;
      item_cycles.push_back(c);
   endfunction

   function automatic void add_col_row(longint col, longint row);
      add_cycle(K_ADDR, col & 255, 1'b0);
      add_cycle(K_ADDR, (col >> 8) & 255, 1'b0);
      add_cycle(K_ADDR, row & 255, 1'b0);
      add_cycle(K_ADDR, (row >> 8) & 255, 1'b1);
   endfunction

   function automatic void add_read_segment(longint col, longint row, longint count);
      add_cycle(K_CMD, CMD_READ, 1'b0);
      add_col_row(col, row);
      add_cycle(K_CMD, CMD_READ_GO, 1'b0);
      add_cycle(K_WAIT, 0, 1'b0);
      add_cycle(K_RDATA, count, 1'b0);
   endfunction

   function automatic void predict_bus_cycles(req_type r);
      longint a, cnt, col, row, first, seg;
      a   = r.flash_address;
      cnt = r.byte_count;
      col = a % PG;
      row = a / PG;
      case (r.operation)
         OP_READ: begin
            if (col + cnt <= PG) begin
               add_read_segment(col, row, cnt);
               rd_next_addr = '0;
               rd_left      = '0;
               rd_active    = 1'b0;
            end else begin
               first = PG - col;
               add_read_segment(col, row, first);
               rd_next_addr = 27'(a + first);
               rd_left      = 25'(cnt - first);
               rd_active    = rd_left != 0;
            end
         end
         OP_PROGRAM: begin
            add_cycle(K_CMD, CMD_PROG, 1'b0);
            add_col_row(col, row);
            add_cycle(K_WDATA, (cnt > PG) ? PG : cnt, 1'b0);
            add_cycle(K_CMD, CMD_PROG_GO, 1'b0);
            add_cycle(K_WAIT, 0, 1'b0);
            add_cycle(K_CMD, CMD_STATUS, 1'b0);
            add_cycle(K_STATUS, 0, 1'b0);
         end
         OP_ERASE: begin
            add_cycle(K_CMD, CMD_ERASE, 1'b0);
            add_cycle(K_ADDR, row & 255, 1'b0);
            add_cycle(K_ADDR, (row >> 8) & 255, 1'b1);
            add_cycle(K_CMD, CMD_ERASE_GO, 1'b0);
            add_cycle(K_WAIT, 0, 1'b0);
            add_cycle(K_CMD, CMD_STATUS, 1'b0);
            add_cycle(K_STATUS, 0, 1'b0);
         end
         OP_READ_ID: begin
            add_cycle(K_CMD, CMD_READ_ID, 1'b0);
            add_cycle(K_ADDR, 0, 1'b1);
            add_cycle(K_WAIT, 0, 1'b0);
            add_cycle(K_RDATA, ID_N, 1'b0);
         end
         OP_SPARE: begin
            add_read_segment(PG, longint'(r.block_number) * PPB, SPARE_N);
         end
         OP_ADVANCE: begin
            if (rd_active) begin
               seg = (rd_left > PG) ? PG : rd_left;
               add_read_segment(rd_next_addr % PG, rd_next_addr / PG, seg);
               rd_next_addr = 27'(rd_next_addr + seg);
               rd_left      = 25'(rd_left - seg);
               rd_active    = rd_left != 0;
            end else begin
               add_cycle(K_DONE, 0, 1'b0);
            end
         end
         default: begin
            add_cycle(K_DONE, 0, 1'b0);
         end
      endcase
      foreach (item_cycles[i]) begin
         item_cycles[i].read_pending = rd_active;
         item_cycles[i].last         = (i == item_cycles.size() - 1);
         bus_cycles_due.push_back(item_cycles[i]);
      end
      item_cycles.delete();
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [26:0] addr,
                                        logic [24:0] cnt, logic [9:0] blk);
      req_type r;
      r.operation     = op;
      r.flash_address = addr;
      r.byte_count    = cnt;
      r.block_number  = blk;
      return r;
   endfunction

   function automatic req_type rand_req(logic [2:0] op);
      return make_req(op, 27'($urandom), 25'($urandom), 10'($urandom));
   endfunction

   task automatic push_request(input req_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      repeat (gap) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      predict_bus_cycles(r);
      op_seen[r.operation]++;
   endtask

   task automatic advance_until_idle();
      while (rd_active)
         push_request(rand_req(OP_ADVANCE));
   endtask

   // response side: random stall after each item
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait = rx_wait - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         got = rsp_item;
         cycles_checked++;
         if (bus_cycles_due.size() == 0) begin
            $error("unexpected bus cycle: kind %0d value 0x%0h", got.cycle_kind,
                   got.cycle_value);
            errors++;
         end else begin
            want = bus_cycles_due.pop_front();
            if (got.cycle_kind !== want.cycle_kind) begin
               $error("cycle_kind: expected %0d, got %0d", want.cycle_kind, got.cycle_kind);
               errors++;
            end
            if (got.cycle_value !== want.cycle_value) begin
               $error("cycle_value: expected 0x%0h, got 0x%0h", want.cycle_value,
                      got.cycle_value);
               errors++;
            end
            if (got.final_address !== want.final_address) begin
               $error("final_address: expected %0b, got %0b", want.final_address,
                      got.final_address);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, got.last);
               errors++;
            end
            if (got.read_pending !== want.read_pending) begin
               $error("read_pending: expected %0b, got %0b", want.read_pending,
                      got.read_pending);
               errors++;
            end
         end
         rx_wait = idle_on ? $urandom_range(0, 3) : 0;
      end
   end

   // watchdog: cycles with no handshake on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("** nand_command_sequencer_top: FAILED **");
      $finish;
   end

   task automatic test_page_reads();
      push_request(make_req(OP_READ, 27'h0000000, 25'd0, 10'($urandom)));
      push_request(make_req(OP_READ, 27'h7FFFFFF, 25'd1, 10'($urandom)));
      push_request(make_req(OP_READ, 27'h0012800, 25'(PG), 10'($urandom)));
   endtask

   task automatic test_split_reads();
      push_request(make_req(OP_READ, 27'h00007D0, 25'd5000, 10'($urandom)));
      advance_until_idle();
      push_request(rand_req(OP_ADVANCE));
      // last column, segment tail wraps to address zero
      push_request(make_req(OP_READ, 27'h7FFFFFF, 25'd3, 10'($urandom)));
      advance_until_idle();
      // a new read drops the pending one
      push_request(make_req(OP_READ, 27'h0000400, 25'd4096, 10'($urandom)));
      push_request(make_req(OP_READ, 27'h0001000, 25'd16, 10'($urandom)));
      push_request(rand_req(OP_ADVANCE));
   endtask

   task automatic test_program_erase();
      push_request(make_req(OP_PROGRAM, 27'h0000000, 25'd0, 10'($urandom)));
      push_request(make_req(OP_PROGRAM, 27'h7FFFFFF, 25'(PG + 1), 10'($urandom)));
      push_request(make_req(OP_PROGRAM, 27'h3A5C123, 25'h1FFFFFF, 10'($urandom)));
      push_request(make_req(OP_ERASE, 27'h0000000, 25'($urandom), 10'($urandom)));
      push_request(make_req(OP_ERASE, 27'h7FFFFFF, 25'($urandom), 10'($urandom)));
   endtask

   task automatic test_id_and_spare();
      push_request(rand_req(OP_READ_ID));
      push_request(make_req(OP_SPARE, 27'($urandom), 25'($urandom), 10'd0));
      push_request(make_req(OP_SPARE, 27'($urandom), 25'($urandom), 10'h3FF));
   endtask

   task automatic test_pending_kept();
      push_request(make_req(OP_READ, 27'h0000100, 25'd3000, 10'($urandom)));
      push_request(rand_req(OP_ERASE));
      push_request(rand_req(OP_RSVD6));
      push_request(rand_req(OP_RSVD7));
      advance_until_idle();
   endtask

   task automatic test_random_traffic();
      int sent, pick, adv;
      longint col, row;
      req_type r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0)
            idle_on = !idle_on;
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            r = rand_req(OP_READ);
            if ($urandom_range(0, 1) == 0) begin
               row = $urandom_range(0, 65535);
               col = PG - $urandom_range(1, 64);
               r.flash_address = 27'(row * PG + col);
            end
            col = r.flash_address % PG;
            case ($urandom_range(0, 3))
               0: r.byte_count = 25'($urandom_range(0, 64));
               1: r.byte_count = 25'($urandom_range(0, 6000));
               2: r.byte_count = 25'(PG - col + $urandom_range(0, 2) - 1);
               default: ;
            endcase
            push_request(r);
            sent++;
            adv = $urandom_range(1, 8);
            while (rd_active && adv > 0) begin
               if ($urandom_range(0, 7) == 0)
                  push_request(rand_req(3'($urandom_range(1, 4))));
               else
                  push_request(rand_req(OP_ADVANCE));
               adv--;
               sent++;
            end
         end else if (pick < 9) begin
            push_request(rand_req(3'($urandom_range(1, 4))));
            sent++;
         end else begin
            push_request(rand_req(3'($urandom)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_page_reads();
      test_split_reads();
      test_program_erase();
      test_id_and_spare();
      test_pending_kept();
      test_random_traffic();

      @(negedge clock);
      push <= 1'b0;
      while (bus_cycles_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("requests: read %0d, program %0d, erase %0d, id %0d, spare %0d, advance %0d,",
               op_seen[OP_READ], op_seen[OP_PROGRAM], op_seen[OP_ERASE],
               op_seen[OP_READ_ID], op_seen[OP_SPARE], op_seen[OP_ADVANCE]);
      $display("reserved %0d; bus cycles checked %0d, mismatches %0d",
               op_seen[OP_RSVD6] + op_seen[OP_RSVD7], cycles_checked, errors);
      if (errors == 0)
         $display("** nand_command_sequencer_top: PASSED **");
      else
         $display("** nand_command_sequencer_top: FAILED **");
      $finish;
   end

endmodule
